// ===== rtl/core/rae_pkg.sv =====
package rae_pkg;

  // Data and field widths
  localparam int DATA_W = 64;
  localparam int OP_W   = 3;
  localparam int RIDX_W = 3;
  localparam int CNT_W  = 6;

  // Instruction codes
  localparam logic [OP_W-1:0] OP_IN  = 3'd0;
  localparam logic [OP_W-1:0] OP_MOV = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD = 3'd2;
  localparam logic [OP_W-1:0] OP_SUB = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL = 3'd4;
  localparam logic [OP_W-1:0] OP_DIV = 3'd5;
  localparam logic [OP_W-1:0] OP_OUT = 3'd6;

endpackage

// ===== rtl/core/register_alu_executor_unit.sv =====
// Register machine that runs one instruction per input transfer on NUM_REGS signed 64-bit
// registers (IN, MOV, ADD, SUB, MUL, DIV, OUT); only OUT produces an output transfer. All
// arithmetic goes through one shared 64-bit adder under a small sequencer, and the input is
// stalled until the current instruction has finished. OUT also waits for the output register
// to be free; MUL runs one add-and-shift step per multiplier bit; DIV runs operand negation,
// one restoring step per quotient bit and a quotient sign fix, or skips all of these when the
// divisor is zero, in which case the destination is left unchanged.
// Register indexes at or above NUM_REGS read as zero and ignore writes. The register file is
// cleared by per-entry valid bits at reset, so no clearing pass is needed.
module register_alu_executor_unit #(
  parameter int NUM_REGS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rae_pkg::OP_W-1:0]            opcode,
  input  logic [rae_pkg::RIDX_W-1:0]          dest_reg,
  input  logic [rae_pkg::RIDX_W-1:0]          src_reg,
  input  logic signed [rae_pkg::DATA_W-1:0]   immediate,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rae_pkg::DATA_W-1:0]   out_value
);

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int EXT_W = (IDX_W + 1 > rae_pkg::RIDX_W) ? IDX_W + 1 : rae_pkg::RIDX_W;
  localparam int DW    = rae_pkg::DATA_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOAD = 9'b000000010,
    S_NEGA = 9'b000000100,
    S_NEGB = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_FIX  = 9'b001000000,
    S_WB   = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t                   state;
  logic [rae_pkg::OP_W-1:0] op;
  logic [IDX_W-1:0]         d_addr;
  logic                     d_ok;
  logic [DW-1:0]            imm;
  logic [DW-1:0]            rd_d;
  logic [DW-1:0]            rd_s;
  logic                     rdv_d;
  logic                     rdv_s;
  logic [DW-1:0]            acc;
  logic [DW-1:0]            op_a;
  logic [DW-1:0]            op_b;
  logic                     q_neg;
  logic [rae_pkg::CNT_W-1:0] cnt;
  logic [DW-1:0]            res;
  logic [NUM_REGS-1:0]      vld;
  logic [DW-1:0]            mem [NUM_REGS];

  logic                     accept;
  logic [EXT_W-1:0]         d_ext;
  logic [EXT_W-1:0]         s_ext;
  logic                     d_in_ok;
  logic                     s_in_ok;
  logic [IDX_W-1:0]         d_in_addr;
  logic [IDX_W-1:0]         s_in_addr;
  logic [DW-1:0]            dv;
  logic [DW-1:0]            sv;
  logic                     wr_en;
  logic                     out_free;
  logic                     cnt_last;

  // Shared adder
  logic [DW-1:0]            add_a;
  logic [DW-1:0]            add_b;
  logic                     add_sub;
  logic [DW:0]              sum;
  logic [DW-1:0]            div_shift;

  assign in_stall  = rst || (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cnt_last  = (cnt == '1);

  // Decode register indexes against the file depth
  assign d_ext     = EXT_W'(dest_reg);
  assign s_ext     = EXT_W'(src_reg);
  assign d_in_ok   = (d_ext < EXT_W'(NUM_REGS));
  assign s_in_ok   = (s_ext < EXT_W'(NUM_REGS));
  assign d_in_addr = d_ext[IDX_W-1:0];
  assign s_in_addr = s_ext[IDX_W-1:0];

  // Unwritten or out-of-range registers read as zero
  assign dv = rdv_d ? rd_d : '0;
  assign sv = rdv_s ? rd_s : '0;

  assign wr_en     = (state == S_WB) && d_ok;
  assign div_shift = {acc[DW-2:0], op_a[DW-1]};

  // Select adder operands per step
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state)
      S_LOAD: begin
        add_a   = dv;
        add_b   = sv;
        add_sub = (op == rae_pkg::OP_SUB);
      end
      S_NEGA, S_FIX: begin
        add_b   = op_a;
        add_sub = 1'b1;
      end
      S_NEGB: begin
        add_b   = op_b;
        add_sub = 1'b1;
      end
      S_MUL: begin
        add_a   = acc;
        add_b   = op_a;
      end
      S_DIV: begin
        add_a   = div_shift;
        add_b   = op_b;
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (DW + 1)'(add_sub);

  // Sequence control, valid bits and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      vld       <= '0;
      rdv_d     <= 1'b0;
      rdv_s     <= 1'b0;
    end else begin
      // Raise the output from the OUT step, drop it after a transfer
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        vld[d_addr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rdv_d <= d_in_ok && vld[d_in_addr];
            rdv_s <= s_in_ok && vld[s_in_addr];
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt <= '0;
          case (op)
            rae_pkg::OP_IN, rae_pkg::OP_MOV, rae_pkg::OP_ADD, rae_pkg::OP_SUB: begin
              state <= S_WB;
            end
            rae_pkg::OP_MUL: state <= S_MUL;
            rae_pkg::OP_DIV: state <= (sv == '0) ? S_IDLE : S_NEGA;
            rae_pkg::OP_OUT: state <= S_OUT;
            default:         state <= S_IDLE;
          endcase
        end
        S_NEGA: state <= S_NEGB;
        S_NEGB: state <= S_DIV;
        S_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            state <= S_WB;
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            state <= S_FIX;
          end
        end
        S_FIX: state <= S_WB;
        S_WB:  state <= S_IDLE;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Register file storage and read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[d_addr] <= res;
    end
    if (accept) begin
      rd_d <= mem[d_in_addr];
      rd_s <= mem[s_in_addr];
    end
  end

  // Datapath: operand latch, multiply and divide steps, result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op     <= opcode;
          d_addr <= d_in_addr;
          d_ok   <= d_in_ok;
          imm    <= immediate;
        end
      end
      S_LOAD: begin
        acc   <= '0;
        op_a  <= dv;
        op_b  <= sv;
        q_neg <= dv[DW-1] ^ sv[DW-1];
        case (op)
          rae_pkg::OP_IN:                  res <= imm;
          rae_pkg::OP_MOV:                 res <= sv;
          rae_pkg::OP_ADD, rae_pkg::OP_SUB: res <= sum[DW-1:0];
          rae_pkg::OP_OUT:                 res <= dv;
          default:                         res <= res;
        endcase
      end
      // Take magnitudes of dividend and divisor
      S_NEGA: begin
        if (op_a[DW-1]) begin
          op_a <= sum[DW-1:0];
        end
      end
      S_NEGB: begin
        if (op_b[DW-1]) begin
          op_b <= sum[DW-1:0];
        end
      end
      // Add the shifted multiplicand for each set multiplier bit
      S_MUL: begin
        if (op_b[0]) begin
          acc <= sum[DW-1:0];
        end
        op_a <= {op_a[DW-2:0], 1'b0};
        op_b <= {1'b0, op_b[DW-1:1]};
        if (cnt_last) begin
          res <= op_b[0] ? sum[DW-1:0] : acc;
        end
      end
      // Restoring step: carry out means the trial subtract fits
      S_DIV: begin
        acc  <= sum[DW] ? sum[DW-1:0] : div_shift;
        op_a <= {op_a[DW-2:0], sum[DW]};
      end
      S_FIX: begin
        res <= q_neg ? sum[DW-1:0] : op_a;
      end
      S_OUT: begin
        if (out_free) begin
          out_value <= res;
        end
      end
      default: begin
        res <= res;
      end
    endcase
  end

  // An output transfer is only raised from the OUT step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("output raised outside OUT step");

  // An accepted instruction always moves to operand load
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_LOAD))
    else $error("accepted instruction did not start");

  // Multiply and divide loops run the full count before leaving
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_MUL || state == S_DIV) && !cnt_last) |=> (state == $past(state)))
    else $error("iteration loop left early");

  // The register file is written only for an in-range destination
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) && !d_ok |=> $stable(vld))
    else $error("write to out-of-range register");

endmodule

// ===== dv/register_alu_executor_unit_tb.sv =====
`timescale 1ns / 1ps

module register_alu_executor_unit_tb;

  localparam int NUM_REGS = 8;
  localparam int RANDOM_ITEMS = 1500;
  localparam int DRAIN_CYCLES = 150;
  // Worst case is 1525 items, each busy as long as a divide, then the longest send gap and output stall
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [rae_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

  localparam logic [rae_pkg::DATA_W-1:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [rae_pkg::DATA_W-1:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [rae_pkg::DATA_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [rae_pkg::OP_W-1:0]      opcode;
  logic [rae_pkg::RIDX_W-1:0]    dest_reg;
  logic [rae_pkg::RIDX_W-1:0]    src_reg;
  logic [rae_pkg::DATA_W-1:0]    immediate;
  logic                          out_valid;
  logic                          out_stall;
  logic [rae_pkg::DATA_W-1:0]    out_value;

  bit                  quiet;
  int unsigned         cycle_count;

  // Shadow register machine: tracks the file and the OUT values still owed
  class regfile_scoreboard;
    logic [rae_pkg::DATA_W-1:0] regs [NUM_REGS];
    logic [rae_pkg::DATA_W-1:0] owed_outs [$];
    int unsigned                errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
    endfunction

    function logic [rae_pkg::DATA_W-1:0] read_reg(logic [rae_pkg::RIDX_W-1:0] idx);
      if (idx < NUM_REGS) return regs[idx];
      return '0;
    endfunction

    function void write_reg(logic [rae_pkg::RIDX_W-1:0] idx,
                            logic [rae_pkg::DATA_W-1:0] v);
      if (idx < NUM_REGS) regs[idx] = v;
    endfunction

    // Divide magnitudes, then restore the sign; truncates toward zero
    function logic [rae_pkg::DATA_W-1:0] quot_trunc(logic [rae_pkg::DATA_W-1:0] a,
                                                    logic [rae_pkg::DATA_W-1:0] b);
      logic [rae_pkg::DATA_W-1:0] ma, mb, q;
      ma = a[rae_pkg::DATA_W-1] ? 64'd0 - a : a;
      mb = b[rae_pkg::DATA_W-1] ? 64'd0 - b : b;
      q = ma / mb;
      return (a[rae_pkg::DATA_W-1] ^ b[rae_pkg::DATA_W-1]) ? 64'd0 - q : q;
    endfunction

    // Apply one accepted instruction; OUT owes one output transfer
    function void note_instr(logic [rae_pkg::OP_W-1:0] op, logic [rae_pkg::RIDX_W-1:0] d,
                             logic [rae_pkg::RIDX_W-1:0] s,
                             logic [rae_pkg::DATA_W-1:0] imm);
      logic [rae_pkg::DATA_W-1:0] dv, sv;
      dv = read_reg(d);
      sv = read_reg(s);
      case (op)
        rae_pkg::OP_IN:  write_reg(d, imm);
        rae_pkg::OP_MOV: write_reg(d, sv);
        rae_pkg::OP_ADD: write_reg(d, dv + sv);
        rae_pkg::OP_SUB: write_reg(d, dv - sv);
        rae_pkg::OP_MUL: write_reg(d, dv * sv);
        rae_pkg::OP_DIV: begin
          if (sv != '0) write_reg(d, quot_trunc(dv, sv));
        end
        rae_pkg::OP_OUT: owed_outs.push_back(dv);
        default: ;
      endcase
    endfunction

    function void check_out_value(logic [rae_pkg::DATA_W-1:0] got);
      logic [rae_pkg::DATA_W-1:0] want;
      if (owed_outs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: output transfer with nothing owed, out_value=%h", got);
        return;
      end
      want = owed_outs.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("ERROR: out_value expected %h, got %h", want, got);
      end
    endfunction

    function int pending();
      return owed_outs.size();
    endfunction
  endclass

  regfile_scoreboard board = new();

  register_alu_executor_unit #(
    .NUM_REGS(NUM_REGS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .dest_reg (dest_reg),
    .src_reg  (src_reg),
    .immediate(immediate),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Mostly short gaps, a few long ones; none while quiet
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [rae_pkg::DATA_W-1:0] pick_imm();
    case ($urandom_range(0, 9))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return ALL_ONES;
      3: return '0;
      4, 5: return 64'($signed($urandom_range(0, 200)) - 100);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Present one instruction, hold it until the transfer, then idle a while
  task automatic issue(logic [rae_pkg::OP_W-1:0] op, logic [rae_pkg::RIDX_W-1:0] d,
                       logic [rae_pkg::RIDX_W-1:0] s, logic [rae_pkg::DATA_W-1:0] imm);
    int gap;
    in_valid  <= 1'b1;
    opcode    <= op;
    dest_reg  <= d;
    src_reg   <= s;
    immediate <= imm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_instr(op, d, s, imm);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue_random();
    int r;
    logic [rae_pkg::OP_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 20)      op = rae_pkg::OP_IN;
    else if (r < 28) op = rae_pkg::OP_MOV;
    else if (r < 40) op = rae_pkg::OP_ADD;
    else if (r < 52) op = rae_pkg::OP_SUB;
    else if (r < 65) op = rae_pkg::OP_MUL;
    else if (r < 78) op = rae_pkg::OP_DIV;
    else if (r < 97) op = rae_pkg::OP_OUT;
    else             op = OP_UNUSED;
    issue(op, rae_pkg::RIDX_W'($urandom_range(0, 7)), rae_pkg::RIDX_W'($urandom_range(0, 7)),
          pick_imm());
  endtask

  // Check every completed output transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_out_value(out_value);
  end

  // Stall the output side in random bursts
  initial begin
    int run_len, gap;
    forever begin
      run_len = $urandom_range(1, 8);
      out_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Bound the run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    quiet     = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    opcode    <= rae_pkg::OP_IN;
    dest_reg  <= '0;
    src_reg   <= '0;
    immediate <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset contents, extremes, wraparound and division corners
    issue(rae_pkg::OP_OUT, 3'd5, 3'd0, ALL_ONES);
    issue(rae_pkg::OP_IN,  3'd0, 3'd7, MOST_POS);
    issue(rae_pkg::OP_IN,  3'd1, 3'd0, MOST_NEG);
    issue(rae_pkg::OP_IN,  3'd2, 3'd0, ALL_ONES);
    issue(rae_pkg::OP_MOV, 3'd3, 3'd1, '0);
    issue(rae_pkg::OP_DIV, 3'd3, 3'd2, '0);
    issue(rae_pkg::OP_OUT, 3'd3, 3'd0, '0);
    issue(rae_pkg::OP_ADD, 3'd0, 3'd0, '0);
    issue(rae_pkg::OP_OUT, 3'd0, 3'd0, '0);
    issue(rae_pkg::OP_SUB, 3'd1, 3'd1, '0);
    issue(rae_pkg::OP_OUT, 3'd1, 3'd0, '0);
    issue(rae_pkg::OP_DIV, 3'd0, 3'd1, '0);
    issue(rae_pkg::OP_OUT, 3'd0, 3'd0, '0);
    issue(rae_pkg::OP_MUL, 3'd2, 3'd2, '0);
    issue(rae_pkg::OP_OUT, 3'd2, 3'd0, '0);
    issue(rae_pkg::OP_IN,  3'd4, 3'd0, 64'hFFFF_FFFF_FFFF_FFF9);
    issue(rae_pkg::OP_IN,  3'd5, 3'd0, 64'd2);
    issue(rae_pkg::OP_DIV, 3'd4, 3'd5, '0);
    issue(rae_pkg::OP_OUT, 3'd4, 3'd0, '0);
    issue(rae_pkg::OP_MOV, 3'd6, 3'd6, MOST_NEG);
    issue(OP_UNUSED, 3'd7, 3'd7, ALL_ONES);
    issue(rae_pkg::OP_OUT, 3'd6, 3'd7, MOST_POS);
    issue(rae_pkg::OP_MUL, 3'd4, 3'd0, '0);
    issue(rae_pkg::OP_OUT, 3'd4, 3'd0, '0);
    issue(rae_pkg::OP_OUT, 3'd7, 3'd7, ALL_ONES);

    // Random instructions, with stretches of back-to-back traffic
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = ((i / 250) % 3) == 1;
      issue_random();
    end
    quiet = 1'b0;

    // Drain owed results, then allow for trailing activity
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== register_alu_executor_unit.f =====
rtl/core/rae_pkg.sv
rtl/core/register_alu_executor_unit.sv
dv/register_alu_executor_unit_tb.sv
